@@ hw/rtl/first_fit_arena_allocator_macros.svh @@
// Assertion macros used by the allocator top-level RTL.
// Each macro expects clk and rst_n in scope.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants for the first-fit arena allocator and its segment cells.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_SEGMENTS = 64;

    localparam int OFS_W = 12;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADFREE = 2'd3
    } status_t;

    // What the request beat is doing as it passes a cell
    typedef enum logic [2:0] {
        M_SEARCH = 3'd0,
        M_INSERT = 3'd1,
        M_SHIFT1 = 3'd2,
        M_SHIFT2 = 3'd3,
        M_DONE   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1,
        S_RESP = 2'd2
    } state_t;

    typedef struct packed {
        logic             vld;
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] size;
        logic             free;
    } ent_t;

    typedef struct packed {
        logic             act;
        cmd_t             cmd;
        mode_t            mode;
        logic [OFS_W-1:0] want;
        logic [OFS_W-1:0] addr;
        logic             full;
        status_t          status;
        logic [OFS_W-1:0] ofs;
        logic [OFS_W-1:0] c_start;
        logic [OFS_W-1:0] c_size;
        logic             c_free;
        logic             grow;
        logic [1:0]       shrink;
    } pkt_t;

    localparam logic [OFS_W-1:0] HDR = OFS_W'(HEADER_BYTES);

    localparam ent_t INIT_ENT = '{
        vld:   1'b1,
        start: '0,
        size:  OFS_W'(ARENA_BYTES - HEADER_BYTES),
        free:  1'b1
    };

endpackage

@@ hw/rtl/first_fit_arena_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit arena allocator over a chain of segment cells.
// ----------------------------------------------------------------------------
// Input channel: cmd, req_size, req_addr with in_valid/in_ready. cmd selects
// allocate (req_size payload bytes) or free (req_addr payload offset).
// Output channel: status, payload_offset with out_valid/out_ready; one result
// beat for every request beat, in order.
// A request enters cell 0 and walks the segment chain one cell per cycle,
// splitting, marking and merging entries as it passes. out_valid rises once
// the beat has left the last cell and the state has moved from run to
// response. One request is in flight at a time, and a new beat is taken the
// cycle after the result is delivered.
// The walk length is set by the number of cells in the chain.
// Reset leaves one free segment covering the arena minus one header.
// If the receiver stalls, the result holds on the outputs and in_ready stays
// low until out_ready is seen.
`include "first_fit_arena_allocator_macros.svh"

module first_fit_arena_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [11:0] req_size,
    input  logic [11:0] req_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [11:0] payload_offset
);
    import ffa_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    status_t          status_reg, status_next;
    logic [OFS_W-1:0] ofs_reg, ofs_next;

    ent_t ent [MAX_SEGMENTS];
    pkt_t pkt [MAX_SEGMENTS+1];
    pkt_t done_pkt;
    logic accept;

    assign accept   = in_valid && in_ready;
    assign done_pkt = pkt[MAX_SEGMENTS];

    always_comb
    begin
        pkt[0]        = '0;
        pkt[0].act    = accept;
        pkt[0].cmd    = cmd_t'(cmd);
        pkt[0].mode   = M_SEARCH;
        pkt[0].want   = req_size;
        pkt[0].addr   = req_addr;
        pkt[0].full   = (count_reg == CNT_W'(MAX_SEGMENTS));
        pkt[0].status = (cmd_t'(cmd) == CMD_ALLOC) ? ST_NOFIT : ST_BADFREE;
    end

    for (genvar k = 0; k < MAX_SEGMENTS; k++)
    begin : g_cell
        ent_t n1, n2;
        if (k + 1 < MAX_SEGMENTS)
        begin : g_n1
            assign n1 = ent[k+1];
        end
        else
        begin : g_n1_end
            assign n1 = '0;
        end
        if (k + 2 < MAX_SEGMENTS)
        begin : g_n2
            assign n2 = ent[k+2];
        end
        else
        begin : g_n2_end
            assign n2 = '0;
        end
        ffa_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .first (k == 0),
            .pkt_i (pkt[k]),
            .nxt1  (n1),
            .nxt2  (n2),
            .ent_o (ent[k]),
            .pkt_o (pkt[k+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_RUN;
            S_RUN:   if (done_pkt.act) state_next = S_RESP;
            S_RESP:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and bookkeeping
    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        out_valid   = (state_reg == S_RESP);
        count_next  = count_reg;
        status_next = status_reg;
        ofs_next    = ofs_reg;
        if (done_pkt.act)
        begin
            status_next = done_pkt.status;
            ofs_next    = (done_pkt.status == ST_OK) ? done_pkt.ofs : '0;
            if (done_pkt.status == ST_OK)
            begin
                count_next = count_reg + CNT_W'(done_pkt.grow)
                           - CNT_W'(done_pkt.shrink);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ofs_reg    <= ofs_next;
    end

    assign status         = status_reg;
    assign payload_offset = ofs_reg;

    `FFA_ASSERT_IMP(a_count_range, 1'b1, (count_reg != '0) && (count_reg <= CNT_W'(MAX_SEGMENTS)), "segment count out of range")
    `FFA_ASSERT_IMP(a_done_in_run, done_pkt.act, state_reg == S_RUN, "walk finished outside run state")
    `FFA_ASSERT_IMP(a_fail_zero, out_valid && (status != ST_OK), payload_offset == '0, "failed result carries offset")
    `FFA_ASSERT_NXT(a_accept_run, accept, (state_reg == S_RUN) && !in_ready, "accept did not start walk")

endmodule

@@ hw/rtl/ffa_cell.sv @@
// ----------------------------------------------------------------------------
// ffa_cell
// One segment table entry. Applies the request beat passing through it and
// hands the registered beat on to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module ffa_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          first,
    input  ffa_pkg::pkt_t pkt_i,
    input  ffa_pkg::ent_t nxt1,
    input  ffa_pkg::ent_t nxt2,
    output ffa_pkg::ent_t ent_o,
    output ffa_pkg::pkt_t pkt_o
);
    import ffa_pkg::*;

    ent_t ent_reg, ent_next;
    pkt_t pkt_reg, pkt_next;

    logic [OFS_W:0] need;
    logic [OFS_W:0] hit_here_sum;
    logic [OFS_W:0] hit_next_sum;
    logic           hit_here;
    logic           hit_next;

    assign need         = {1'b0, pkt_i.want} + {1'b0, HDR};
    assign hit_here_sum = {1'b0, ent_reg.start} + {1'b0, HDR};
    assign hit_next_sum = {1'b0, nxt1.start} + {1'b0, HDR};
    assign hit_here     = ent_reg.vld && (hit_here_sum == {1'b0, pkt_i.addr});
    assign hit_next     = nxt1.vld && (hit_next_sum == {1'b0, pkt_i.addr});

    always_comb
    begin
        ent_next = ent_reg;
        pkt_next = pkt_i;
        if (pkt_i.act)
        begin
            unique case (pkt_i.mode)
                M_SEARCH:
                begin
                    if (pkt_i.cmd == CMD_ALLOC)
                    begin
                        if (ent_reg.vld && ent_reg.free && (pkt_i.want != '0))
                        begin
                            if (ent_reg.size == pkt_i.want)
                            begin
                                ent_next.free   = 1'b0;
                                pkt_next.status = ST_OK;
                                pkt_next.ofs    = ent_reg.start + HDR;
                                pkt_next.mode   = M_DONE;
                            end
                            else if ({1'b0, ent_reg.size} > need)
                            begin
                                if (pkt_i.full)
                                begin
                                    pkt_next.status = ST_FULL;
                                    pkt_next.mode   = M_DONE;
                                end
                                else
                                begin
                                    // split: remainder rides the beat as carry
                                    pkt_next.c_start = ent_reg.start + HDR + pkt_i.want;
                                    pkt_next.c_size  = ent_reg.size - pkt_i.want - HDR;
                                    pkt_next.c_free  = 1'b1;
                                    ent_next.size    = pkt_i.want;
                                    ent_next.free    = 1'b0;
                                    pkt_next.status  = ST_OK;
                                    pkt_next.ofs     = ent_reg.start + HDR;
                                    pkt_next.grow    = 1'b1;
                                    pkt_next.mode    = M_INSERT;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (hit_here)
                        begin
                            if (ent_reg.free)
                            begin
                                pkt_next.mode = M_DONE;
                            end
                            else
                            begin
                                ent_next.free   = 1'b1;
                                pkt_next.status = ST_OK;
                                if (nxt1.vld && nxt1.free)
                                begin
                                    ent_next.size   = ent_reg.size + HDR + nxt1.size;
                                    pkt_next.shrink = 2'd1;
                                    pkt_next.mode   = M_SHIFT1;
                                end
                                else
                                begin
                                    pkt_next.mode = M_DONE;
                                end
                            end
                        end
                        else if (hit_next && ent_reg.free)
                        begin
                            if (nxt1.free)
                            begin
                                pkt_next.mode = M_DONE;
                            end
                            else
                            begin
                                // absorb the released neighbor, and the one after if free
                                pkt_next.status = ST_OK;
                                if (nxt2.vld && nxt2.free)
                                begin
                                    ent_next.size   = ent_reg.size + HDR + nxt1.size
                                                    + HDR + nxt2.size;
                                    pkt_next.shrink = 2'd2;
                                    pkt_next.mode   = M_SHIFT2;
                                end
                                else
                                begin
                                    ent_next.size   = ent_reg.size + HDR + nxt1.size;
                                    pkt_next.shrink = 2'd1;
                                    pkt_next.mode   = M_SHIFT1;
                                end
                            end
                        end
                    end
                end
                M_INSERT:
                begin
                    ent_next.vld     = 1'b1;
                    ent_next.start   = pkt_i.c_start;
                    ent_next.size    = pkt_i.c_size;
                    ent_next.free    = pkt_i.c_free;
                    // carry becomes the displaced entry, keep its mark
                    pkt_next.c_start = ent_reg.start;
                    pkt_next.c_size  = ent_reg.size;
                    pkt_next.c_free  = ent_reg.free;
                    if (!ent_reg.vld)
                    begin
                        pkt_next.mode = M_DONE;
                    end
                end
                M_SHIFT1: ent_next = nxt1;
                M_SHIFT2: ent_next = nxt2;
                M_DONE:   ent_next = ent_reg;
                default:  ent_next = ent_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= first ? INIT_ENT : '0;
            pkt_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
            pkt_reg <= pkt_next;
        end
    end

    assign ent_o = ent_reg;
    assign pkt_o = pkt_reg;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// first_fit_arena_allocator testbench
// Drives allocate and free requests, predicts each status and payload offset
// with a behavioral segment table, and checks every result beat in order.
// ----------------------------------------------------------------------------
module testbench;
    import ffa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             cmd;
        logic [OFS_W-1:0] size;
        logic [OFS_W-1:0] addr;
    } req_t;

    typedef struct packed {
        status_t          st;
        logic [OFS_W-1:0] ofs;
    } rsp_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             cmd;
    logic [11:0]      req_size;
    logic [11:0]      req_addr;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       status;
    logic [11:0]      payload_offset;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   live_offsets[$];
    int   errors;
    int   results_seen;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_send;
    bit   stim_done;

    // allocator table model
    int tbl_start[MAX_SEGMENTS];
    int tbl_size[MAX_SEGMENTS];
    bit tbl_free[MAX_SEGMENTS];
    int tbl_count;

    first_fit_arena_allocator dut (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void table_remove(input int at);
        for (int k = at; k + 1 < tbl_count; k++)
        begin
            tbl_start[k] = tbl_start[k + 1];
            tbl_size[k]  = tbl_size[k + 1];
            tbl_free[k]  = tbl_free[k + 1];
        end
        tbl_count--;
    endfunction

    function automatic rsp_t predict_allocation(input req_t r);
        rsp_t res;
        int   want;
        res.st  = ST_NOFIT;
        res.ofs = '0;
        want = r.size;
        if (r.cmd == CMD_ALLOC)
        begin
            if (want == 0)
                return res;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (!tbl_free[i])
                    continue;
                if (tbl_size[i] == want)
                begin
                    tbl_free[i] = 1'b0;
                    res.st  = ST_OK;
                    res.ofs = OFS_W'(tbl_start[i] + HEADER_BYTES);
                    return res;
                end
                if (tbl_size[i] > want + HEADER_BYTES)
                begin
                    if (tbl_count >= MAX_SEGMENTS)
                    begin
                        res.st = ST_FULL;
                        return res;
                    end
                    for (int k = tbl_count; k > i + 1; k--)
                    begin
                        tbl_start[k] = tbl_start[k - 1];
                        tbl_size[k]  = tbl_size[k - 1];
                        tbl_free[k]  = tbl_free[k - 1];
                    end
                    tbl_start[i + 1] = tbl_start[i] + HEADER_BYTES + want;
                    tbl_size[i + 1]  = tbl_size[i] - want - HEADER_BYTES;
                    tbl_free[i + 1]  = 1'b1;
                    tbl_count++;
                    tbl_size[i] = want;
                    tbl_free[i] = 1'b0;
                    res.st  = ST_OK;
                    res.ofs = OFS_W'(tbl_start[i] + HEADER_BYTES);
                    return res;
                end
            end
            return res;
        end
        res.st = ST_BADFREE;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_start[i] + HEADER_BYTES == int'(r.addr))
            begin
                if (tbl_free[i])
                    return res;
                tbl_free[i] = 1'b1;
                // coalesce every run of free neighbors
                for (int j = 0; j + 1 < tbl_count; )
                begin
                    if (tbl_free[j] && tbl_free[j + 1])
                    begin
                        tbl_size[j] = tbl_size[j] + tbl_size[j + 1] + HEADER_BYTES;
                        table_remove(j + 1);
                    end
                    else
                        j++;
                end
                res.st = ST_OK;
                return res;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= 1'b0;
            req_size <= '0;
            req_addr <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid && in_ready)
                void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && !hold_send
                && $urandom_range(99, 0) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                cmd      <= pending_reqs[0].cmd;
                req_size <= pending_reqs[0].size;
                req_addr <= pending_reqs[0].addr;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // predict on accepted request beats
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_rsps.push_back(predict_allocation({cmd, req_size, req_addr}));
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected beat, status", status, -1);
                else
                begin
                    rsp_t e;
                    e = expected_rsps.pop_front();
                    if (status !== e.st)
                        report_mismatch("status", status, e.st);
                    if (payload_offset !== e.ofs)
                        report_mismatch("payload_offset", payload_offset, e.ofs);
                end
            end
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    function automatic req_t mk_alloc(input int sz);
        return '{cmd: CMD_ALLOC, size: OFS_W'(sz), addr: OFS_W'($urandom)};
    endfunction

    function automatic req_t mk_free(input int ad);
        return '{cmd: CMD_FREE, size: OFS_W'($urandom), addr: OFS_W'(ad)};
    endfunction

    // sample between edges so queue updates of the last edge are all seen
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
            @(negedge clk);
    endtask

    // random mix: mostly small allocations and frees of live offsets
    task automatic queue_random(input int n);
        int sel;
        int ofs;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99, 0);
            if (sel < 45)
            begin
                ofs = ($urandom_range(9, 0) == 0) ? $urandom_range(4095, 0)
                                                  : $urandom_range(96, 1);
                pending_reqs.push_back(mk_alloc(ofs));
            end
            else if (sel < 85 && live_offsets.size() > 0)
            begin
                int idx;
                idx = $urandom_range(live_offsets.size() - 1, 0);
                pending_reqs.push_back(mk_free(live_offsets[idx]));
                live_offsets.delete(idx);
            end
            else
                pending_reqs.push_back(mk_free($urandom_range(4095, 0)));
        end
    endtask

    // track offsets handed out so frees hit real segments
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && status == ST_OK && payload_offset != 0)
            live_offsets.push_back(payload_offset);
    end

    initial
    begin
        errors = 0;
        results_seen = 0;
        hold_send = 1'b0;
        stim_done = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 75;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            tbl_start[i] = 0;
            tbl_size[i]  = 0;
            tbl_free[i]  = 1'b0;
        end
        tbl_size[0] = ARENA_BYTES - HEADER_BYTES;
        tbl_free[0] = 1'b1;
        tbl_count = 1;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero size, oversize, exact fit, bad frees, double free
        pending_reqs.push_back(mk_alloc(0));
        pending_reqs.push_back(mk_alloc(4095));
        pending_reqs.push_back(mk_free(0));
        pending_reqs.push_back(mk_alloc(ARENA_BYTES - HEADER_BYTES));
        pending_reqs.push_back(mk_alloc(1));
        pending_reqs.push_back(mk_free(HEADER_BYTES));
        pending_reqs.push_back(mk_free(HEADER_BYTES));
        pending_reqs.push_back(mk_alloc(100));
        pending_reqs.push_back(mk_alloc(200));
        pending_reqs.push_back(mk_free(HEADER_BYTES + 5));
        pending_reqs.push_back(mk_free(HEADER_BYTES));
        pending_reqs.push_back(mk_alloc(100));
        pending_reqs.push_back(mk_free(4095));
        pending_reqs.push_back(mk_free(2 * HEADER_BYTES + 100));
        pending_reqs.push_back(mk_free(HEADER_BYTES));
        wait_drained();

        // fill the table with tiny blocks to reach the full condition
        for (int i = 0; i < MAX_SEGMENTS + 2; i++)
            pending_reqs.push_back(mk_alloc(1));
        pending_reqs.push_back(mk_alloc(2));
        wait_drained();
        // release everything, exercising merge of whole runs
        for (int i = 0; i < MAX_SEGMENTS; i++)
            pending_reqs.push_back(mk_free(HEADER_BYTES + i * (HEADER_BYTES + 1)));
        live_offsets.delete();
        wait_drained();

        queue_random(360);
        wait_drained();
        send_idle_pct = 75;
        recv_idle_pct = 9;
        queue_random(360);
        // pause the sender until everything outstanding has returned
        hold_send = 1'b1;
        @(negedge clk);
        while (expected_rsps.size() > 0 || in_valid)
            @(negedge clk);
        hold_send = 1'b0;
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(360);
        wait_drained();
        repeat (2 * MAX_SEGMENTS + 10) @(posedge clk);
        if (expected_rsps.size() != 0)
            report_mismatch("results still outstanding", 0, expected_rsps.size());

        $display("Covered %0d results: zero/oversize allocs, exact fits, splits,",
                 results_seen);
        $display("table full, bad and double frees, coalescing, under three idle mixes.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_cell.sv
hw/rtl/first_fit_arena_allocator.sv
dv/testbench.sv
